// ===== src/sgbs_pkg.sv =====
// Shared types and constants for the switch gate burst sequencer.
// No dependencies; every other file refers to it by scoped names.
package sgbs_pkg;

  localparam int unsigned PERIOD_TICKS_DEF = 1200;

  localparam int unsigned CYC_W   = 8;
  localparam int unsigned PHASE_W = 4;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned CMP_W   = 7;
  localparam int unsigned CFG_IDX_W = 1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CYCLE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_VARIANT = 1'd1;

  // phase codes, full variant
  localparam logic [PHASE_W-1:0] PH_IDLE       = 4'd0;
  localparam logic [PHASE_W-1:0] PH_START      = 4'd1;
  localparam logic [PHASE_W-1:0] PH_LEAD       = 4'd2;
  localparam logic [PHASE_W-1:0] PH_ON         = 4'd3;
  localparam logic [PHASE_W-1:0] PH_OFF1       = 4'd4;
  localparam logic [PHASE_W-1:0] PH_OFF2       = 4'd5;
  localparam logic [PHASE_W-1:0] PH_FULL_ON    = 4'd7;
  localparam logic [PHASE_W-1:0] PH_FULL_LEAD  = 4'd8;
  localparam logic [PHASE_W-1:0] PH_FULL_HOLD  = 4'd9;
  localparam logic [PHASE_W-1:0] PH_FULL_OFF   = 4'd10;
  // phase codes, simple variant
  localparam logic [PHASE_W-1:0] PH_SIMPLE_ON  = 4'd2;
  localparam logic [PHASE_W-1:0] PH_SIMPLE_OFF = 4'd3;

  localparam logic [CNT_W-1:0] LEAD_TICKS = 11'd100;
  localparam logic [CNT_W-1:0] CLIP_LOW   = 11'd100;
  localparam logic [CNT_W-1:0] OFF_GUARD1 = 11'd100;
  localparam logic [CNT_W-1:0] OFF_GUARD2 = 11'd10;
  localparam logic [CNT_W-1:0] MIN_ON     = 11'd4;
  localparam logic [CNT_W-1:0] CNT_MAX    = 11'd2047;
  localparam logic [CMP_W-1:0] CMP_ON     = 7'd100;
  localparam logic [CMP_W-1:0] CMP_OFF    = 7'd0;

  typedef struct packed {
    logic               mode;
    logic [PHASE_W-1:0] phase_request;
    logic               work_active;
  } item_t;

  typedef struct packed {
    logic             variant;
    logic [CNT_W-1:0] on_ticks;
    logic [CNT_W-1:0] off_ticks;
  } timing_t;

  typedef struct packed {
    logic               open_drive;
    logic               pulse_drive;
    logic [CMP_W-1:0]   pwm_compare;
    logic [PHASE_W-1:0] phase_now;
  } result_t;

endpackage

// ===== src/sgbs_if.sv =====
// Channel interfaces: input words, result words and configuration writes.
// Depends on sgbs_pkg for field widths.
interface sgbs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [sgbs_pkg::PHASE_W-1:0] phase_request;
  logic                        work_active;
  modport source (output valid, output mode, output phase_request, output work_active,
                  input ready);
  modport sink (input valid, input mode, input phase_request, input work_active,
                output ready);
endinterface

interface sgbs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        open_drive;
  logic                        pulse_drive;
  logic [sgbs_pkg::CMP_W-1:0]   pwm_compare;
  logic [sgbs_pkg::PHASE_W-1:0] phase_now;
  modport source (output valid, output open_drive, output pulse_drive, output pwm_compare,
                  output phase_now, input ready);
  modport sink (input valid, input open_drive, input pulse_drive, input pwm_compare,
                input phase_now, output ready);
endinterface

interface sgbs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sgbs_pkg::CFG_IDX_W-1:0] idx;
  logic [sgbs_pkg::CYC_W-1:0]     data;
  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

// ===== src/sgbs_cfg.sv =====
// Configuration registers and on/off tick derivation.
// Depends on sgbs_pkg and sgbs_cfg_if.
module sgbs_cfg #(
  parameter int unsigned PERIOD_TICKS = sgbs_pkg::PERIOD_TICKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  sgbs_cfg_if.sink          cfg_ch,
  output sgbs_pkg::timing_t timing
);

  localparam logic [sgbs_pkg::CNT_W-1:0] PERIOD_V = sgbs_pkg::CNT_W'(PERIOD_TICKS);
  localparam logic [sgbs_pkg::CNT_W-1:0] CLIP_HIGH = sgbs_pkg::CNT_W'(PERIOD_TICKS - 100);

  logic [sgbs_pkg::CYC_W-1:0] cycle_r;
  logic                       variant_r;
  logic [sgbs_pkg::CNT_W-1:0] raw_ticks;
  logic [sgbs_pkg::CNT_W-1:0] on_ticks;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_r   <= '0;
      variant_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        sgbs_pkg::CFG_IDX_CYCLE:   cycle_r   <= cfg_ch.data;
        sgbs_pkg::CFG_IDX_VARIANT: variant_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // six times the cycle value as 4x + 2x
  assign raw_ticks = {1'b0, cycle_r, 2'b00} + {2'b00, cycle_r, 1'b0};

  always_comb begin
    if (raw_ticks < sgbs_pkg::CLIP_LOW) begin
      on_ticks = '0;
    end else if (raw_ticks > CLIP_HIGH) begin
      on_ticks = PERIOD_V;
    end else begin
      on_ticks = raw_ticks;
    end
  end

  assign timing.variant   = variant_r;
  assign timing.on_ticks  = on_ticks;
  assign timing.off_ticks = PERIOD_V - on_ticks;

endmodule

// ===== src/sgbs_core.sv =====
// Phase, tick counter and line level state with the per-word update logic.
// Depends on sgbs_pkg.
module sgbs_core #(
  parameter int unsigned PERIOD_TICKS = sgbs_pkg::PERIOD_TICKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  sgbs_pkg::item_t   item,
  input  sgbs_pkg::timing_t timing,
  output sgbs_pkg::result_t res_nxt
);

  localparam logic [sgbs_pkg::CNT_W-1:0] FULL_GUARD = sgbs_pkg::CNT_W'(PERIOD_TICKS - 10);

  logic [sgbs_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [sgbs_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                         open_r, open_nxt;
  logic                         pulse_r, pulse_nxt;
  logic [sgbs_pkg::CMP_W-1:0]   cmp_r, cmp_nxt;

  logic [sgbs_pkg::CNT_W-1:0] cnt_inc;
  logic                       off_done;

  assign cnt_inc = (cnt_r < sgbs_pkg::CNT_MAX) ? cnt_r + 1'b1 : cnt_r;

  always_comb begin
    logic [sgbs_pkg::CNT_W-1:0] c;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    open_nxt  = open_r;
    pulse_nxt = pulse_r;
    cmp_nxt   = cmp_r;
    c         = cnt_r;
    off_done  = 1'b0;
    if (item.mode) begin
      phase_nxt = item.phase_request;
    end else if (timing.variant) begin
      case (phase_r)
        sgbs_pkg::PH_IDLE: phase_nxt = sgbs_pkg::PH_LEAD;
        sgbs_pkg::PH_START: begin
          phase_nxt = sgbs_pkg::PH_LEAD;
          cnt_nxt   = '0;
        end
        sgbs_pkg::PH_LEAD, sgbs_pkg::PH_FULL_LEAD: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= sgbs_pkg::LEAD_TICKS) begin
            phase_nxt = (phase_r == sgbs_pkg::PH_LEAD) ? sgbs_pkg::PH_ON
                                                       : sgbs_pkg::PH_FULL_HOLD;
            cnt_nxt   = '0;
            pulse_nxt = 1'b1;
          end
        end
        sgbs_pkg::PH_ON: begin
          c       = (timing.on_ticks < FULL_GUARD) ? cnt_inc : cnt_r;
          cnt_nxt = c;
          if (c >= timing.on_ticks) begin
            phase_nxt = sgbs_pkg::PH_OFF1;
            cnt_nxt   = '0;
            open_nxt  = 1'b0;
          end
        end
        sgbs_pkg::PH_OFF1: begin
          c        = (timing.off_ticks > sgbs_pkg::OFF_GUARD1) ? cnt_inc : cnt_r;
          cnt_nxt  = c;
          off_done = (c >= timing.off_ticks) && item.work_active
                     && (timing.on_ticks > sgbs_pkg::MIN_ON);
          if (off_done) begin
            phase_nxt = sgbs_pkg::PH_OFF2;
            cnt_nxt   = '0;
            open_nxt  = 1'b1;
            cmp_nxt   = sgbs_pkg::CMP_ON;
          end
        end
        sgbs_pkg::PH_OFF2: begin
          c        = (timing.off_ticks > sgbs_pkg::OFF_GUARD2) ? cnt_inc : cnt_r;
          cnt_nxt  = c;
          off_done = (c >= timing.off_ticks) && item.work_active
                     && (timing.on_ticks > sgbs_pkg::MIN_ON);
          if (off_done) begin
            phase_nxt = sgbs_pkg::PH_LEAD;
            cnt_nxt   = '0;
            pulse_nxt = 1'b0;
          end
        end
        sgbs_pkg::PH_FULL_ON: begin
          if (item.work_active) begin
            phase_nxt = sgbs_pkg::PH_FULL_LEAD;
            cnt_nxt   = '0;
            pulse_nxt = 1'b0;
            open_nxt  = 1'b1;
            cmp_nxt   = sgbs_pkg::CMP_ON;
          end
        end
        sgbs_pkg::PH_FULL_OFF: begin
          phase_nxt = sgbs_pkg::PH_FULL_HOLD;
          cnt_nxt   = '0;
          open_nxt  = 1'b0;
        end
        default: ;  // hold on phases without meaning here
      endcase
    end else begin
      case (phase_r)
        sgbs_pkg::PH_IDLE: phase_nxt = sgbs_pkg::PH_SIMPLE_ON;
        sgbs_pkg::PH_START: begin
          phase_nxt = sgbs_pkg::PH_SIMPLE_ON;
          cnt_nxt   = '0;
        end
        sgbs_pkg::PH_SIMPLE_ON: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= timing.on_ticks) begin
            phase_nxt = sgbs_pkg::PH_SIMPLE_OFF;
            cnt_nxt   = '0;
            cmp_nxt   = sgbs_pkg::CMP_OFF;
          end
        end
        sgbs_pkg::PH_SIMPLE_OFF: begin
          cnt_nxt  = cnt_inc;
          off_done = (cnt_inc >= timing.off_ticks) && item.work_active
                     && (timing.on_ticks > sgbs_pkg::MIN_ON);
          if (off_done) begin
            phase_nxt = sgbs_pkg::PH_SIMPLE_ON;
            cnt_nxt   = '0;
            cmp_nxt   = sgbs_pkg::CMP_ON;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sgbs_pkg::PH_IDLE;
      cnt_r   <= '0;
      open_r  <= 1'b0;
      pulse_r <= 1'b0;
      cmp_r   <= sgbs_pkg::CMP_OFF;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      open_r  <= open_nxt;
      pulse_r <= pulse_nxt;
      cmp_r   <= cmp_nxt;
    end
  end

  assign res_nxt.open_drive  = open_nxt;
  assign res_nxt.pulse_drive = pulse_nxt;
  assign res_nxt.pwm_compare = cmp_nxt;
  assign res_nxt.phase_now   = phase_nxt;

`ifndef NO_ASSERTIONS
  a_cmd_sets_phase: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.mode |=> phase_r == $past(item.phase_request))
    else $error("command word did not set the phase");

  a_cmd_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.mode |=> $stable(cnt_r) && $stable(open_r) && $stable(pulse_r))
    else $error("command word changed counter or line levels");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !item.mode && phase_r == sgbs_pkg::PH_START |=>
      cnt_r == '0 && phase_r == sgbs_pkg::PH_LEAD)
    else $error("start tick did not clear the counter");

  a_cmp_levels: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_r == sgbs_pkg::CMP_OFF || cmp_r == sgbs_pkg::CMP_ON)
    else $error("compare value is neither off nor on");

  a_idle_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(phase_r) && $stable(cnt_r) && $stable(cmp_r))
    else $error("state changed without a word");
`endif

endmodule

// ===== src/switch_gate_burst_sequencer.sv =====
// Top level of the switch gate burst sequencer: input register, result register
// and handshake. Depends on sgbs_pkg, sgbs_if, sgbs_cfg and sgbs_core.
//
//  channel | direction | payload                                          | accepted when
//  in_ch   | in        | mode, phase_request, work_active                 | valid && ready
//  out_ch  | out       | open_drive, pulse_drive, pwm_compare, phase_now  | valid && ready
//  cfg_ch  | in        | idx (0 cycle_setting, 1 sequence_variant), data  | valid && ready
//
// One word per cycle sustained while out_ch is ready; a taken word passes the input
// register, then the phase update into the result register.
// cfg_ch.ready is always high; a write takes effect on the next cycle.
// Reset (rst_n low, synchronous) empties both registers and returns phase, counter
// and line levels to zero, cycle_setting to 0 and sequence_variant to 1.
// A stalled out_ch holds its result; in_ch still takes one more word into the
// input register, then ready drops until the result is taken.
module switch_gate_burst_sequencer #(
  parameter int unsigned PERIOD_TICKS = sgbs_pkg::PERIOD_TICKS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  sgbs_in_if.sink    in_ch,
  sgbs_out_if.source out_ch,
  sgbs_cfg_if.sink   cfg_ch
);

  logic              s1_valid_r;
  sgbs_pkg::item_t   s1_item_r;
  logic              out_valid_r;
  sgbs_pkg::result_t out_res_r;

  logic              out_free;
  logic              s1_fire;
  sgbs_pkg::timing_t timing;
  sgbs_pkg::result_t res_nxt;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;

  sgbs_cfg #(.PERIOD_TICKS(PERIOD_TICKS)) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .timing (timing)
  );

  sgbs_core #(.PERIOD_TICKS(PERIOD_TICKS)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_fire),
    .item    (s1_item_r),
    .timing  (timing),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload registers: load on advance, hold otherwise
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r.mode          <= in_ch.mode;
      s1_item_r.phase_request <= in_ch.phase_request;
      s1_item_r.work_active   <= in_ch.work_active;
    end
    if (s1_fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.open_drive  = out_res_r.open_drive;
  assign out_ch.pulse_drive = out_res_r.pulse_drive;
  assign out_ch.pwm_compare = out_res_r.pwm_compare;
  assign out_ch.phase_now   = out_res_r.phase_now;

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready && s1_valid_r |=> s1_valid_r && $stable(s1_item_r))
    else $error("input register overwritten while the result stalls");

  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("processed word did not reach the result register");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ch.ready)
    else $error("input refused while the input register is empty");
`endif

endmodule
